/* sv/nc_pkg.sv */
`timescale 1ns / 1ps
// Shared types and codes for the nested conditional stack.
// No dependencies; used by every module of the block.
package nc_pkg;

    localparam int MAX_NEST_DEF = 1024;

    // Function codes of an input item
    localparam logic [3:0] FN_CMD      = 4'd0;
    localparam logic [3:0] FN_IF       = 4'd1;
    localparam logic [3:0] FN_ELIF     = 4'd2;
    localparam logic [3:0] FN_ELSE     = 4'd3;
    localparam logic [3:0] FN_ENDIF    = 4'd4;
    localparam logic [3:0] FN_CLEAR    = 4'd5;
    localparam logic [3:0] FN_RESTORE  = 4'd6;
    localparam logic [3:0] FN_FINALIZE = 4'd7;
    localparam logic [3:0] FN_CHECK    = 4'd8;

    // Error codes of a result item
    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_OVERFLOW   = 3'd1;
    localparam logic [2:0] ERR_UNMATCHED  = 3'd2;
    localparam logic [2:0] ERR_COND       = 3'd3;
    localparam logic [2:0] ERR_UNBALANCED = 3'd4;
    localparam logic [2:0] ERR_DEPTH      = 3'd5;

    // Last keyword seen at a level
    localparam logic [2:0] KW_NONE  = 3'd0;
    localparam logic [2:0] KW_IF    = 3'd1;
    localparam logic [2:0] KW_ELIF  = 3'd2;
    localparam logic [2:0] KW_ELSE  = 3'd3;
    localparam logic [2:0] KW_ENDIF = 3'd4;

    typedef struct packed {
        logic [3:0] func;
        logic       cond;
        logic       cond_error;
        logic [9:0] depth_value;
    } cmd_t;

    typedef struct packed {
        logic       skip;
        logic [2:0] error;
        logic [9:0] depth;
        logic       all_true;
    } result_t;

    // One stack entry; prefix is the AND of taken over levels 1 up to this one
    typedef struct packed {
        logic       taken;
        logic       seen;
        logic [2:0] kw;
        logic       prefix;
    } entry_t;

    typedef struct packed {
        logic       wr_en;
        entry_t     entry;
        logic [2:0] err;
        logic       pop;
        logic       all_true;
    } lvl_res_t;

endpackage

/* sv/nc_stack_ram.sv */
`timescale 1ns / 1ps
// Level store: one write port, two registered read ports.
// Depends on nc_pkg for the entry type.
module nc_stack_ram #(
    parameter int DEPTH = nc_pkg::MAX_NEST_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic            clk,
    input  logic            we,
    input  logic [AW-1:0]   waddr,
    input  nc_pkg::entry_t  wdata,
    input  logic [AW-1:0]   raddr_a,
    input  logic [AW-1:0]   raddr_b,
    output nc_pkg::entry_t  rdata_a,
    output nc_pkg::entry_t  rdata_b
);

    nc_pkg::entry_t mem [DEPTH];
    nc_pkg::entry_t rdata_a_reg;
    nc_pkg::entry_t rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_a_reg <= mem[raddr_a];
        rdata_b_reg <= mem[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

/* sv/nc_level_logic.sv */
`timescale 1ns / 1ps
// Update of the top level for elif, else and endif.
// Depends on nc_pkg for codes and the entry and result types.
module nc_level_logic (
    input  logic [3:0]       func,
    input  logic             cond,
    input  logic             cond_error,
    input  logic             d_zero,
    input  nc_pkg::entry_t   top,
    input  logic             pm1,
    output nc_pkg::lvl_res_t res
);

    logic [2:0] kw;
    logic       new_true;

    assign kw       = d_zero ? nc_pkg::KW_NONE : top.kw;
    assign new_true = !top.taken && !top.seen;

    always_comb
    begin
        res          = '0;
        res.entry    = top;
        res.err      = nc_pkg::ERR_NONE;
        res.all_true = 1'b1;
        case (func)
            nc_pkg::FN_ELIF, nc_pkg::FN_ELSE:
            begin
                if (kw != nc_pkg::KW_IF && kw != nc_pkg::KW_ELIF)
                begin
                    res.err = nc_pkg::ERR_UNMATCHED;
                end
                else
                begin
                    res.wr_en        = 1'b1;
                    res.entry.kw     = (func == nc_pkg::FN_ELSE) ? nc_pkg::KW_ELSE
                                                                 : nc_pkg::KW_ELIF;
                    res.entry.taken  = new_true;
                    res.entry.prefix = pm1 && new_true;
                    res.all_true     = pm1 && new_true;
                    // An elif whose branch opens evaluates its condition as a fresh if
                    if (func == nc_pkg::FN_ELIF && pm1 && new_true)
                    begin
                        if (cond_error)
                        begin
                            res.err = nc_pkg::ERR_COND;
                        end
                        else
                        begin
                            res.entry.taken  = cond;
                            res.entry.seen   = cond;
                            res.entry.kw     = nc_pkg::KW_IF;
                            res.entry.prefix = cond;
                            res.all_true     = cond;
                        end
                    end
                end
            end
            nc_pkg::FN_ENDIF:
            begin
                if (kw != nc_pkg::KW_IF && kw != nc_pkg::KW_ELIF && kw != nc_pkg::KW_ELSE)
                begin
                    res.err = nc_pkg::ERR_UNMATCHED;
                end
                else
                begin
                    res.wr_en      = 1'b1;
                    res.entry.kw   = nc_pkg::KW_ENDIF;
                    res.entry.seen = 1'b0;
                    res.pop        = 1'b1;
                    res.all_true   = pm1;
                end
            end
            default:
            begin
                res.wr_en = 1'b0;
            end
        endcase
    end

endmodule

/* sv/nested_conditional_stack.sv */
`timescale 1ns / 1ps
// Nesting stack for if / elif / else / endif in a command stream.
// Depends on nc_pkg, nc_stack_ram and nc_level_logic.
//
// An item is taken at a rising edge with start high and busy low. Its result
// is on the result port for one cycle with done high; the receiver cannot
// stall, so done is gone after that cycle.
//
// Handling by item kind:
//   command, if, clear, finalize, check: result registered from the idle
//   state, and a new item can be taken in the very next cycle (busy stays low).
//   elif, else, endif, and restore to a depth not above the current one:
//   result from the exec state after the read-modify-write of the level store
//   through its registered read; busy is high until then, so no new item is taken.
//   restore to a deeper level: the scan state rewrites each reopened level in
//   turn to rebuild its stored all-true prefix bit.
//
// Each level holds a prefix bit (all levels up to it true), so the all-true
// test is one register and never a search over the stack.
//
// After reset the level store is cleared, one entry a cycle, from entry 0 up
// to MAX_NEST - 1; busy is high during that pass.
module nested_conditional_stack #(
    parameter int MAX_NEST = nc_pkg::MAX_NEST_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  nc_pkg::cmd_t     cmd,
    output logic             done,
    output nc_pkg::result_t  result
);

    localparam int AW = $clog2(MAX_NEST);

    typedef enum logic [1:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_SCAN
    } state_t;

    state_t          state_reg, state_next;
    logic [AW-1:0]   depth_reg, depth_next;
    logic            all_true_reg, all_true_next;
    nc_pkg::cmd_t    cmd_reg, cmd_next;
    logic [AW-1:0]   target_reg, target_next;
    logic [AW-1:0]   scan_rd_reg, scan_rd_next;
    logic [AW-1:0]   scan_wr_reg, scan_wr_next;
    logic            scan_pend_reg, scan_pend_next;
    logic            running_reg, running_next;
    logic [AW-1:0]   clr_reg, clr_next;
    logic            done_reg, done_next;
    nc_pkg::result_t result_reg, result_next;

    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    nc_pkg::entry_t  mem_wdata;
    logic [AW-1:0]   raddr_a;
    logic [AW-1:0]   raddr_b;
    nc_pkg::entry_t  rdata_a;
    nc_pkg::entry_t  rdata_b;
    logic [AW-1:0]   v_sat;
    logic [31:0]     dval_ext;
    nc_pkg::lvl_res_t lvl;

    assign dval_ext = 32'(cmd.depth_value);
    assign v_sat    = (dval_ext > 32'(MAX_NEST - 1)) ? AW'(MAX_NEST - 1) : AW'(dval_ext);

    assign raddr_a = (state_reg == ST_SCAN) ? scan_rd_reg : depth_reg;
    assign raddr_b = (cmd.func == nc_pkg::FN_RESTORE) ? v_sat : (depth_reg - AW'(1));

    nc_stack_ram #(
        .DEPTH (MAX_NEST),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    nc_level_logic u_level (
        .func       (cmd_reg.func),
        .cond       (cmd_reg.cond),
        .cond_error (cmd_reg.cond_error),
        .d_zero     (depth_reg == '0),
        .top        (rdata_a),
        .pm1        (rdata_b.prefix),
        .res        (lvl)
    );

    always_comb
    begin
        logic        fin;
        logic        fin_skip;
        logic [2:0]  fin_err;
        logic        newp;
        logic        ovf;
        logic [31:0] dext;

        state_next     = state_reg;
        depth_next     = depth_reg;
        all_true_next  = all_true_reg;
        cmd_next       = cmd_reg;
        target_next    = target_reg;
        scan_rd_next   = scan_rd_reg;
        scan_wr_next   = scan_wr_reg;
        scan_pend_next = scan_pend_reg;
        running_next   = running_reg;
        clr_next       = clr_reg;
        done_next      = 1'b0;
        result_next    = result_reg;
        mem_we         = 1'b0;
        mem_waddr      = depth_reg;
        mem_wdata      = '0;
        fin            = 1'b0;
        fin_skip       = 1'b0;
        fin_err        = nc_pkg::ERR_NONE;
        newp           = 1'b0;
        ovf            = (32'(depth_reg) == 32'(MAX_NEST - 1));

        unique case (state_reg)
            ST_INIT:
            begin
                // Entry 0 stands for the outermost scope: its prefix is true
                mem_we           = 1'b1;
                mem_waddr        = clr_reg;
                mem_wdata.kw     = nc_pkg::KW_NONE;
                mem_wdata.prefix = (clr_reg == '0);
                if (32'(clr_reg) == 32'(MAX_NEST - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + AW'(1);
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd_next    = cmd;
                    target_next = v_sat;
                    case (cmd.func) inside
                        nc_pkg::FN_ELIF, nc_pkg::FN_ELSE, nc_pkg::FN_ENDIF,
                        nc_pkg::FN_RESTORE:
                        begin
                            state_next = ST_EXEC;
                        end
                        nc_pkg::FN_IF:
                        begin
                            fin      = 1'b1;
                            fin_skip = 1'b1;
                            if (all_true_reg && cmd.cond_error)
                            begin
                                fin_err = nc_pkg::ERR_COND;
                            end
                            else if (ovf)
                            begin
                                fin_err = nc_pkg::ERR_OVERFLOW;
                            end
                            else
                            begin
                                // Push; a blocked if opens a false level
                                newp          = all_true_reg && cmd.cond;
                                mem_we        = 1'b1;
                                mem_waddr     = depth_reg + AW'(1);
                                mem_wdata     = '{taken: newp, seen: newp,
                                                  kw: nc_pkg::KW_IF, prefix: newp};
                                depth_next    = depth_reg + AW'(1);
                                all_true_next = newp;
                            end
                        end
                        nc_pkg::FN_CLEAR:
                        begin
                            fin           = 1'b1;
                            depth_next    = '0;
                            all_true_next = 1'b1;
                        end
                        nc_pkg::FN_FINALIZE:
                        begin
                            fin     = 1'b1;
                            fin_err = all_true_reg ? nc_pkg::ERR_NONE
                                                   : nc_pkg::ERR_UNBALANCED;
                        end
                        nc_pkg::FN_CHECK:
                        begin
                            fin     = 1'b1;
                            fin_err = (32'(depth_reg) != dval_ext) ? nc_pkg::ERR_DEPTH
                                                                   : nc_pkg::ERR_NONE;
                        end
                        default:
                        begin
                            fin      = 1'b1;
                            fin_skip = !all_true_reg;
                        end
                    endcase
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
                if (cmd_reg.func == nc_pkg::FN_RESTORE)
                begin
                    if (target_reg <= depth_reg)
                    begin
                        fin           = 1'b1;
                        depth_next    = target_reg;
                        all_true_next = rdata_b.prefix;
                    end
                    else
                    begin
                        // Rebuild prefix bits of the levels that reopen
                        state_next     = ST_SCAN;
                        scan_rd_next   = depth_reg + AW'(1);
                        scan_pend_next = 1'b0;
                        running_next   = all_true_reg;
                    end
                end
                else
                begin
                    fin           = 1'b1;
                    fin_skip      = 1'b1;
                    fin_err       = lvl.err;
                    mem_we        = lvl.wr_en;
                    mem_waddr     = depth_reg;
                    mem_wdata     = lvl.entry;
                    depth_next    = lvl.pop ? (depth_reg - AW'(1)) : depth_reg;
                    all_true_next = lvl.all_true;
                end
            end
            ST_SCAN:
            begin
                if (scan_pend_reg)
                begin
                    newp             = running_reg && rdata_a.taken;
                    mem_we           = 1'b1;
                    mem_waddr        = scan_wr_reg;
                    mem_wdata        = rdata_a;
                    mem_wdata.prefix = newp;
                    running_next     = newp;
                    if (scan_wr_reg == target_reg)
                    begin
                        fin           = 1'b1;
                        depth_next    = target_reg;
                        all_true_next = newp;
                        state_next    = ST_IDLE;
                    end
                end
                scan_wr_next   = scan_rd_reg;
                scan_rd_next   = scan_rd_reg + AW'(1);
                scan_pend_next = 1'b1;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Any error drops the stack back to depth 0
        if (fin && fin_err != nc_pkg::ERR_NONE)
        begin
            depth_next    = '0;
            all_true_next = 1'b1;
        end

        dext = 32'(depth_next);
        if (fin)
        begin
            done_next            = 1'b1;
            result_next.skip     = fin_skip;
            result_next.error    = fin_err;
            result_next.depth    = dext[9:0];
            result_next.all_true = all_true_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            depth_reg     <= '0;
            all_true_reg  <= 1'b1;
            cmd_reg       <= '0;
            target_reg    <= '0;
            scan_rd_reg   <= '0;
            scan_wr_reg   <= '0;
            scan_pend_reg <= 1'b0;
            running_reg   <= 1'b0;
            clr_reg       <= '0;
            done_reg      <= 1'b0;
            result_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            depth_reg     <= depth_next;
            all_true_reg  <= all_true_next;
            cmd_reg       <= cmd_next;
            target_reg    <= target_next;
            scan_rd_reg   <= scan_rd_next;
            scan_wr_reg   <= scan_wr_next;
            scan_pend_reg <= scan_pend_next;
            running_reg   <= running_next;
            clr_reg       <= clr_next;
            done_reg      <= done_next;
            result_reg    <= result_next;
        end
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

/* bench/tb_nested_conditional_stack.sv */
`timescale 1ns / 1ps
// Testbench for nested_conditional_stack: drives scripted and random items (commands, if/elif/else/endif,
// clear, restore, finalize, check) and checks every result against a behavioral nesting-stack predictor.
// Depends on nc_pkg and nested_conditional_stack.
module tb_nested_conditional_stack;

    localparam int         NEST_LIMIT    = nc_pkg::MAX_NEST_DEF;
    localparam logic [3:0] FN_SPARE_LAST = 4'd15;
    localparam int         RANDOM_ITEMS  = 950;
    localparam int         MAX_REPORTS   = 10;

    typedef struct {
        nc_pkg::cmd_t c;
        bit           drain_first;
    } script_item_t;

    logic            clk;
    logic            rst_n;
    logic            start = 1'b0;
    nc_pkg::cmd_t    cmd = '0;
    logic            busy;
    logic            done;
    nc_pkg::result_t result;

    script_item_t    script_q[$];
    nc_pkg::result_t pending_results[$];

    logic       lvl_taken [NEST_LIMIT];
    logic       lvl_seen  [NEST_LIMIT];
    logic [2:0] lvl_kw    [NEST_LIMIT];
    int         nest_lvl;

    int items_taken;
    int results_seen;
    int error_results;
    int deepest;
    int mismatches;
    int burst_left;
    int gap_left;

    nested_conditional_stack #(
        .MAX_NEST(NEST_LIMIT)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    function automatic void reset_predictor();
        for (int i = 0; i < NEST_LIMIT; i++)
        begin
            lvl_taken[i] = 1'b0;
            lvl_seen[i]  = 1'b0;
            lvl_kw[i]    = nc_pkg::KW_NONE;
        end
        nest_lvl = 0;
    endfunction

    function automatic bit open_levels_true();
        for (int i = 1; i <= nest_lvl && i < NEST_LIMIT; i++)
        begin
            if (!lvl_taken[i])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic [2:0] open_level(bit taken);
        if (nest_lvl + 1 >= NEST_LIMIT)
            return nc_pkg::ERR_OVERFLOW;
        nest_lvl++;
        lvl_taken[nest_lvl] = taken;
        lvl_seen[nest_lvl]  = taken;
        lvl_kw[nest_lvl]    = nc_pkg::KW_IF;
        return nc_pkg::ERR_NONE;
    endfunction

    // Advance the stack by one item and return the result it should produce
    function automatic nc_pkg::result_t nest_predict(nc_pkg::cmd_t c);
        nc_pkg::result_t r;
        int              d;
        logic [2:0]      top_kw;
        r = '0;
        d = nest_lvl;
        top_kw = (d > 0 && d < NEST_LIMIT) ? lvl_kw[d] : nc_pkg::KW_NONE;
        case (c.func)
            nc_pkg::FN_IF:
            begin
                r.skip = 1'b1;
                // a blocked if opens a false level and never looks at its condition
                if (!open_levels_true())
                    r.error = open_level(1'b0);
                else if (c.cond_error)
                    r.error = nc_pkg::ERR_COND;
                else
                    r.error = open_level(c.cond);
            end
            nc_pkg::FN_ELIF, nc_pkg::FN_ELSE:
            begin
                r.skip = 1'b1;
                if (top_kw != nc_pkg::KW_IF && top_kw != nc_pkg::KW_ELIF)
                    r.error = nc_pkg::ERR_UNMATCHED;
                else
                begin
                    lvl_kw[d] = (c.func == nc_pkg::FN_ELSE) ? nc_pkg::KW_ELSE
                                                            : nc_pkg::KW_ELIF;
                    if (lvl_taken[d])
                        lvl_taken[d] = 1'b0;
                    else if (!lvl_seen[d])
                        lvl_taken[d] = 1'b1;
                    // an elif that opens replaces its level with a fresh one
                    if (c.func == nc_pkg::FN_ELIF && open_levels_true())
                    begin
                        nest_lvl = d - 1;
                        r.error = c.cond_error ? nc_pkg::ERR_COND : open_level(c.cond);
                    end
                end
            end
            nc_pkg::FN_ENDIF:
            begin
                r.skip = 1'b1;
                if (top_kw != nc_pkg::KW_IF && top_kw != nc_pkg::KW_ELIF &&
                    top_kw != nc_pkg::KW_ELSE)
                    r.error = nc_pkg::ERR_UNMATCHED;
                else
                begin
                    lvl_kw[d]   = nc_pkg::KW_ENDIF;
                    lvl_seen[d] = 1'b0;
                    nest_lvl    = d - 1;
                end
            end
            nc_pkg::FN_CLEAR:
                nest_lvl = 0;
            nc_pkg::FN_RESTORE:
                nest_lvl = (c.depth_value > NEST_LIMIT - 1) ? NEST_LIMIT - 1 : c.depth_value;
            nc_pkg::FN_FINALIZE:
                if (!open_levels_true())
                    r.error = nc_pkg::ERR_UNBALANCED;
            nc_pkg::FN_CHECK:
                if (nest_lvl != c.depth_value)
                    r.error = nc_pkg::ERR_DEPTH;
            default:
                r.skip = !open_levels_true();
        endcase
        if (r.error != nc_pkg::ERR_NONE)
            nest_lvl = 0;
        r.depth    = 10'(nest_lvl);
        r.all_true = open_levels_true();
        return r;
    endfunction

    // Append an item and run it through the predictor so the script can follow the depth
    function automatic void queue_item(logic [3:0] f, logic cv, logic ce, logic [9:0] dv,
                                       bit drain);
        script_item_t s;
        s.c.func        = f;
        s.c.cond        = cv;
        s.c.cond_error  = ce;
        s.c.depth_value = dv;
        s.drain_first   = drain;
        void'(nest_predict(s.c));
        script_q.push_back(s);
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #4_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    always @(posedge clk or negedge rst_n)
    begin : drive
        script_item_t nxt;
        if (!rst_n)
        begin
            start      <= 1'b0;
            cmd        <= '0;
            gap_left   = 0;
            burst_left = 1;
        end
        else
        begin
            if (start && !busy)
            begin
                pending_results.push_back(nest_predict(cmd));
                items_taken++;
            end
            // hold the item while the block is busy
            if (!(start && busy))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                    cmd   <= nc_pkg::cmd_t'(16'($urandom_range(0, 65535)));
                end
                else if (script_q.size() != 0 && (!script_q[0].drain_first ||
                         (pending_results.size() == 0 && !done)))
                begin
                    nxt = script_q.pop_front();
                    start <= 1'b1;
                    cmd   <= nxt.c;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 16);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
                    end
                end
                else
                begin
                    start <= 1'b0;
                    cmd   <= nc_pkg::cmd_t'(16'($urandom_range(0, 65535)));
                end
            end
        end
    end

    always @(posedge clk)
    begin : watch
        nc_pkg::result_t want;
        if (rst_n && done !== 1'b0)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                begin
                    $write("%0t: result with no item outstanding: ", $time);
                    $display("skip=%0b error=%0d depth=%0d all_true=%0b",
                             result.skip, result.error, result.depth, result.all_true);
                end
            end
            else
            begin
                want = pending_results.pop_front();
                results_seen++;
                if (want.error != nc_pkg::ERR_NONE)
                    error_results++;
                if (want.depth > deepest)
                    deepest = want.depth;
                if (result.skip !== want.skip || result.error !== want.error ||
                    result.depth !== want.depth || result.all_true !== want.all_true)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $write("%0t: result %0d: expected skip=%0b error=%0d depth=%0d ",
                               $time, results_seen, want.skip, want.error, want.depth);
                        $display("all_true=%0b, got skip=%0b error=%0d depth=%0d all_true=%0b",
                                 want.all_true, result.skip, result.error, result.depth,
                                 result.all_true);
                    end
                end
            end
        end
    end

    initial
    begin : stimulus
        int         sel;
        logic [3:0] f;
        logic       cv;
        logic       ce;
        logic [9:0] dv;
        reset_predictor();

        queue_item(nc_pkg::FN_CHECK, 1'b0, 1'b0, 10'd0, 1'b0);
        queue_item(nc_pkg::FN_CHECK, 1'b1, 1'b1, 10'h3FF, 1'b0);
        queue_item(nc_pkg::FN_CMD, 1'b0, 1'b0, 10'd0, 1'b0);
        queue_item(nc_pkg::FN_ENDIF, 1'b0, 1'b0, 10'd0, 1'b0);
        queue_item(nc_pkg::FN_ELSE, 1'b0, 1'b0, 10'd0, 1'b0);
        queue_item(nc_pkg::FN_ELIF, 1'b1, 1'b0, 10'd0, 1'b0);
        // nested block with an elif that opens
        queue_item(nc_pkg::FN_IF, 1'b1, 1'b0, 10'd0, 1'b0);
        queue_item(nc_pkg::FN_IF, 1'b0, 1'b0, 10'd0, 1'b0);
        queue_item(nc_pkg::FN_CMD, 1'b0, 1'b0, 10'd0, 1'b0);
        queue_item(nc_pkg::FN_ELIF, 1'b1, 1'b0, 10'd0, 1'b0);
        queue_item(nc_pkg::FN_CMD, 1'b0, 1'b0, 10'd0, 1'b0);
        queue_item(nc_pkg::FN_ELSE, 1'b0, 1'b0, 10'd0, 1'b0);
        queue_item(nc_pkg::FN_ENDIF, 1'b0, 1'b0, 10'd0, 1'b0);
        queue_item(nc_pkg::FN_ENDIF, 1'b0, 1'b0, 10'd0, 1'b0);
        queue_item(nc_pkg::FN_IF, 1'b1, 1'b1, 10'd0, 1'b0);
        // blocked if ignores its condition error; finalize then sees a false level
        queue_item(nc_pkg::FN_IF, 1'b0, 1'b0, 10'd0, 1'b0);
        queue_item(nc_pkg::FN_IF, 1'b1, 1'b1, 10'd0, 1'b0);
        queue_item(nc_pkg::FN_FINALIZE, 1'b0, 1'b0, 10'd0, 1'b0);
        queue_item(nc_pkg::FN_IF, 1'b1, 1'b0, 10'd0, 1'b0);
        queue_item(nc_pkg::FN_FINALIZE, 1'b0, 1'b0, 10'd0, 1'b0);
        queue_item(nc_pkg::FN_CLEAR, 1'b0, 1'b0, 10'd0, 1'b0);
        queue_item(nc_pkg::FN_IF, 1'b0, 1'b0, 10'd0, 1'b0);
        queue_item(nc_pkg::FN_ELIF, 1'b1, 1'b1, 10'd0, 1'b0);
        // fill the stack to the top, then overflow it
        queue_item(nc_pkg::FN_RESTORE, 1'b0, 1'b0, 10'h3FF, 1'b1);
        queue_item(nc_pkg::FN_IF, 1'b1, 1'b0, 10'd0, 1'b0);
        queue_item(nc_pkg::FN_RESTORE, 1'b0, 1'b0, 10'd0, 1'b0);
        queue_item(nc_pkg::FN_CHECK + 4'd1, 1'b1, 1'b1, 10'h155, 1'b0);
        queue_item(FN_SPARE_LAST, 1'b0, 1'b0, 10'h2AA, 1'b0);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            sel = $urandom_range(0, 99);
            f   = nc_pkg::FN_CMD;
            cv  = $urandom_range(0, 1);
            ce  = ($urandom_range(0, 24) == 0);
            dv  = $urandom_range(0, 1023);
            if (sel < 24)
                f = (nest_lvl < 7) ? nc_pkg::FN_IF : nc_pkg::FN_ENDIF;
            else if (sel < 50)
                f = nc_pkg::FN_CMD;
            else if (sel < 62)
                f = nc_pkg::FN_ELIF;
            else if (sel < 70)
                f = nc_pkg::FN_ELSE;
            else if (sel < 88)
                f = nc_pkg::FN_ENDIF;
            else if (sel < 91)
            begin
                f = nc_pkg::FN_CHECK;
                if ($urandom_range(0, 3) != 0)
                    dv = 10'(nest_lvl);
            end
            else if (sel < 93)
                f = nc_pkg::FN_FINALIZE;
            else if (sel < 95)
            begin
                // mostly shallow restores; a deep one rescans every reopened level
                f = nc_pkg::FN_RESTORE;
                if ($urandom_range(0, 9) != 0)
                    dv = $urandom_range(0, 8);
            end
            else if (sel < 97)
                f = nc_pkg::FN_CLEAR;
            else
                f = 4'($urandom_range(nc_pkg::FN_CHECK + 1, FN_SPARE_LAST));
            // keep most keywords matched at the outer level
            if (nest_lvl == 0 && (f == nc_pkg::FN_ELIF || f == nc_pkg::FN_ELSE ||
                f == nc_pkg::FN_ENDIF) && $urandom_range(0, 4) != 0)
                f = nc_pkg::FN_IF;
            queue_item(f, cv, ce, dv, (n % 160) == 0);
        end

        reset_predictor();

        do
            @(negedge clk);
        while (script_q.size() != 0 || start);
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (8) @(posedge clk);

        $display("Checked %0d results from %0d items; %0d carried an error code.",
                 results_seen, items_taken, error_results);
        $display("Deepest level reported: %0d; mismatches: %0d.", deepest, mismatches);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
